FILE: hdl/wire_occupancy_noise_monitor_defines.svh
// Assertion macros for the wire occupancy noise monitor.
// Used by the top level only; expects clk and rst in scope.
`ifndef WIRE_OCCUPANCY_NOISE_MONITOR_DEFINES_SVH
`define WIRE_OCCUPANCY_NOISE_MONITOR_DEFINES_SVH

// same-cycle implication
`define WONM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WONM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/wonm_pkg.sv
// Shared types and constants of the wire occupancy noise monitor.
// No dependencies.
package wonm_pkg;

  localparam int CNT_W      = 32;
  localparam int WIRE_W     = 12;
  localparam int WIRE_EXT_W = 17;
  localparam int PADDR_W    = 3;
  localparam int PROD_W     = 64;

  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam logic [CNT_W-1:0] THRESH_RESET = 32'd9830;
  localparam logic [1:0]       PLANE_RESET  = 2'd2;

  typedef enum logic [1:0] {
    ACT_HIT   = 2'd0,
    ACT_EVENT = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  typedef enum logic {
    REG_THRESH = 1'b0,
    REG_PLANE  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic             vld;
    logic             wire_ok;
    logic             dead;
    logic [CNT_W-1:0] cnt;
  } stage_t;

endpackage

FILE: hdl/wonm_count_ram.sv
// Per-wire hit counter memory, one write port, one registered read port.
// Depends on wonm_pkg.
module wonm_count_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [wonm_pkg::CNT_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [wonm_pkg::CNT_W-1:0] rdata
);
  import wonm_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/wonm_cfg_regs.sv
// APB-style configuration registers: noise threshold and selected plane.
// Depends on wonm_pkg.
module wonm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wonm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [wonm_pkg::CNT_W-1:0]   threshold,
  output logic [1:0]                  selected_plane
);
  import wonm_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= THRESH_RESET;
      selected_plane <= PLANE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESH: threshold      <= pwdata;
        REG_PLANE:  selected_plane <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESH: prdata = threshold;
      REG_PLANE:  prdata = {30'd0, selected_plane};
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: hdl/wonm_noise_cmp.sv
// Noise test: threshold times event count, then compare with count in Q16.
// Depends on wonm_pkg.
module wonm_noise_cmp (
  input  logic                       clk,
  input  logic                       rst,
  input  wonm_pkg::stage_t           s2,
  input  logic [wonm_pkg::CNT_W-1:0] threshold,
  input  logic [wonm_pkg::CNT_W-1:0] event_count,
  output logic                       done,
  output logic [wonm_pkg::CNT_W-1:0] hit_count,
  output logic                       noisy,
  output logic                       dead,
  output logic [wonm_pkg::CNT_W-1:0] events_seen
);
  import wonm_pkg::*;

  logic              m_vld;
  logic              m_wire_ok;
  logic              m_dead;
  logic [CNT_W-1:0]  m_cnt;
  logic [CNT_W-1:0]  m_events;
  logic [PROD_W-1:0] m_prod;
  logic [PROD_W-1:0] lhs;

  assign lhs = {16'd0, m_cnt, 16'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= s2.vld;
    end
  end

  always_ff @(posedge clk) begin
    m_wire_ok <= s2.wire_ok;
    m_dead    <= s2.dead;
    m_cnt     <= s2.cnt;
    m_events  <= event_count;
    m_prod    <= PROD_W'(threshold) * PROD_W'(event_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    hit_count   <= m_cnt;
    noisy       <= m_wire_ok && (lhs > m_prod);
    dead        <= m_dead;
    events_seen <= m_events;
  end

endmodule

FILE: hdl/wire_occupancy_noise_monitor.sv
// Result strobe (done) follows a transfer through the s1, s2 and compare registers; busy
// holds off the next transfer while the counter memory read-modify-write is under way.
// Results show for one cycle each; the receiver cannot stall.
// After reset busy stays high while every wire counter is cleared.
// Depends on wonm_pkg, wonm_cfg_regs, wonm_count_ram, wonm_noise_cmp.
`include "wire_occupancy_noise_monitor_defines.svh"
module wire_occupancy_noise_monitor #(
  parameter int NUM_WIRES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wonm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [1:0]                   plane,
  input  logic [wonm_pkg::WIRE_W-1:0]  wire_req,
  output logic                         done,
  output logic [wonm_pkg::CNT_W-1:0]   hit_count,
  output logic                         noisy,
  output logic                         dead,
  output logic [wonm_pkg::CNT_W-1:0]   events_seen
);
  import wonm_pkg::*;

  localparam int AW = $clog2(NUM_WIRES);

  logic [CNT_W-1:0]      threshold;
  logic [1:0]            selected_plane;

  ctl_state_t            state;
  ctl_state_t            state_next;
  logic                  clearing;
  logic [AW-1:0]         clr_addr;
  logic                  clr_last;

  logic                  accept;
  logic [WIRE_EXT_W-1:0] wire_ext;
  logic                  in_wire_ok;

  logic                  s1_vld;
  logic                  s1_hit_en;
  logic                  s1_evt_en;
  logic                  s1_wire_ok;
  logic [AW-1:0]         s1_addr;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CNT_W-1:0]      ram_wdata;
  logic [CNT_W-1:0]      ram_rdata;

  logic [CNT_W-1:0]      cnt_upd;
  logic [CNT_W-1:0]      event_count;
  logic [CNT_W-1:0]      event_count_next;
  logic                  any_activity;
  logic                  any_activity_next;
  stage_t                s2;

  wonm_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .threshold      (threshold),
    .selected_plane (selected_plane)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  assign clr_last = (clr_addr == AW'(NUM_WIRES - 1));

  always_comb begin
    unique case (state)
      ST_CLEAR: state_next = clr_last ? ST_RUN : ST_CLEAR;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  assign busy       = clearing || s1_vld;
  assign accept     = start && !busy;
  assign wire_ext   = WIRE_EXT_W'(wire_req);
  assign in_wire_ok = (wire_ext < WIRE_EXT_W'(NUM_WIRES));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_en  <= (action_t'(action) == ACT_HIT) && in_wire_ok &&
                    (plane == selected_plane);
      s1_evt_en  <= (action_t'(action) == ACT_EVENT);
      s1_wire_ok <= in_wire_ok;
      s1_addr    <= wire_ext[AW-1:0];
    end
  end

  wonm_count_ram #(
    .DEPTH (NUM_WIRES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (wire_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign cnt_upd   = (s1_hit_en && ram_rdata != CNT_MAX) ? ram_rdata + CNT_W'(1) : ram_rdata;
  assign ram_we    = clearing || (s1_vld && s1_hit_en);
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : cnt_upd;

  always_comb begin
    event_count_next  = event_count;
    any_activity_next = any_activity;
    if (s1_vld && s1_evt_en && event_count != CNT_MAX) begin
      event_count_next = event_count + CNT_W'(1);
    end
    if (s1_vld && s1_hit_en) begin
      any_activity_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count  <= '0;
      any_activity <= 1'b0;
    end else begin
      event_count  <= event_count_next;
      any_activity <= any_activity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.vld <= 1'b0;
    end else begin
      s2.vld <= s1_vld;
    end
    s2.wire_ok <= s1_wire_ok;
    s2.cnt     <= s1_wire_ok ? cnt_upd : '0;
    s2.dead    <= s1_wire_ok && (cnt_upd == '0) && any_activity_next;
  end

  wonm_noise_cmp u_cmp (
    .clk         (clk),
    .rst         (rst),
    .s2          (s2),
    .threshold   (threshold),
    .event_count (event_count),
    .done        (done),
    .hit_count   (hit_count),
    .noisy       (noisy),
    .dead        (dead),
    .events_seen (events_seen)
  );

  `WONM_ASSERT_NEXT(a_accept_blocks, accept, busy, "transfer did not block the next one")
  `WONM_ASSERT_NOW(a_done_source, done, $past(s1_vld, 3), "result without a transfer")
  `WONM_ASSERT_NOW(a_flags_excl, done, !(noisy && dead), "wire both noisy and dead")

endmodule
